// File: sv/qec_pkg.sv
// Shared types and constants for the quadrature encoder counter.
`default_nettype none

package qec_pkg;

    // Field and register widths
    localparam int HIGH_W     = 15;
    localparam int LOW_W      = 16;
    localparam int GLITCH_W   = 10;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_SAMPLES = 2'd2;

    // Register reset values
    localparam logic [HIGH_W-1:0]   POS_LIMIT_RST = 15'h7FFF;
    localparam logic [LOW_W-1:0]    NEG_LIMIT_RST = 16'h8000;
    localparam logic [GLITCH_W-1:0] GLITCH_RST    = 10'd80;

    // Which limit was reached
    localparam logic LIMIT_HIGH = 1'b0;
    localparam logic LIMIT_LOW  = 1'b1;

    // Filtered phase levels before and after one sample
    typedef struct packed {
        logic old_a;
        logic old_b;
        logic new_a;
        logic new_b;
    } t_edge_info;

    // One result word
    typedef struct packed {
        logic [POS_W-1:0] position_count;
        logic             limit_hit;
        logic             limit_which;
    } t_result;

endpackage

`default_nettype wire

// File: sv/quadrature_encoder_counter.sv
// Top level of the quadrature encoder counter: registers, filters, count, result word.
`default_nettype none

// Takes one sample of phases A and B per cycle while the input is not stalled
// and returns one result word per sample: the x4 position count after that
// sample and a limit flag. Each phase passes a glitch filter that takes a new
// level once the raw level has differed for more than glitch_samples samples
// (capped by the run counter width). A count that reaches the high or the low
// limit is flagged and cleared to zero. Filter state and count update at the
// input accept, and the result lands in an output register in the same edge.
// Input stall follows output stall only while that register holds an unread word.

module quadrature_encoder_counter
    import qec_pkg::*;
#(
    parameter int COUNT_WIDTH  = 16,
    parameter int FILTER_WIDTH = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_phase_a,
    input  wire logic                  i_phase_b,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [POS_W-1:0]           o_position_count,
    output logic                       o_limit_hit,
    output logic                       o_limit_which
);

    logic [HIGH_W-1:0]   r_pos_limit;
    logic [LOW_W-1:0]    r_neg_limit;
    logic [GLITCH_W-1:0] r_glitch_samples;
    logic                r_out_valid;
    t_result             r_result;
    logic                in_accept;
    t_edge_info          edges;
    t_result             result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_limit      <= POS_LIMIT_RST;
            r_neg_limit      <= NEG_LIMIT_RST;
            r_glitch_samples <= GLITCH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_LIMIT:      r_pos_limit      <= i_cfg_data[HIGH_W-1:0];
                CFG_NEG_LIMIT:      r_neg_limit      <= i_cfg_data[LOW_W-1:0];
                CFG_GLITCH_SAMPLES: r_glitch_samples <= i_cfg_data[GLITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a word whenever the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    qec_glitch_filter #(
        .FILTER_WIDTH(FILTER_WIDTH)
    ) u_filter_a (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_accept),
        .i_raw            (i_phase_a),
        .i_glitch_samples (r_glitch_samples),
        .o_level          (edges.old_a),
        .o_next_level     (edges.new_a)
    );

    qec_glitch_filter #(
        .FILTER_WIDTH(FILTER_WIDTH)
    ) u_filter_b (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_accept),
        .i_raw            (i_phase_b),
        .i_glitch_samples (r_glitch_samples),
        .o_level          (edges.old_b),
        .o_next_level     (edges.new_b)
    );

    qec_count_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_accept),
        .i_edges      (edges),
        .i_pos_limit  (r_pos_limit),
        .i_neg_limit  (r_neg_limit),
        .o_result     (result)
    );

    // Output register: load on accept, drop when taken, else hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_count = r_result.position_count;
    assign o_limit_hit      = r_result.limit_hit;
    assign o_limit_which    = r_result.limit_which;

endmodule

`default_nettype wire

// File: sv/qec_glitch_filter.sv
// Glitch filter for one encoder phase: accepts a level after a stable run.
`default_nettype none

module qec_glitch_filter
    import qec_pkg::*;
#(
    parameter int FILTER_WIDTH = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_raw,
    input  wire logic [GLITCH_W-1:0] i_glitch_samples,
    output logic                     o_level,
    output logic                     o_next_level
);

    localparam int LIM_W = (FILTER_WIDTH > GLITCH_W) ? FILTER_WIDTH : GLITCH_W;

    logic                    r_level;
    logic [FILTER_WIDTH-1:0] r_run;
    logic                    n_level;
    logic [FILTER_WIDTH-1:0] n_run;
    logic                    run_full;
    logic                    run_done;

    // A full run counter caps the threshold when the setting exceeds it
    assign run_full = &r_run;
    assign run_done = run_full || (LIM_W'(r_run) >= LIM_W'(i_glitch_samples));

    // Restart, accept or extend the run
    always_comb begin
        n_level = r_level;
        n_run   = r_run;
        if (i_raw == r_level) begin
            n_run = '0;
        end else if (run_done) begin
            n_run   = '0;
            n_level = i_raw;
        end else if (!run_full) begin
            n_run = r_run + FILTER_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_run   <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_run   <= n_run;
        end
    end

    assign o_level      = r_level;
    assign o_next_level = n_level;

endmodule

`default_nettype wire

// File: sv/qec_count_core.sv
// x4 quadrature count with high and low limit detection.
`default_nettype none

module qec_count_core
    import qec_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_edge_info        i_edges,
    input  wire logic [HIGH_W-1:0] i_pos_limit,
    input  wire logic [LOW_W-1:0]  i_neg_limit,
    output t_result                o_result
);

    localparam int EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
    localparam int CMP_W = EXT_W + 1;

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic signed [2:0]      step_a;
    logic signed [2:0]      step_b;
    logic signed [2:0]      delta;
    logic [COUNT_WIDTH-1:0] sum;
    logic signed [CMP_W-1:0] sum_ext;
    logic signed [CMP_W-1:0] high_ext;
    logic signed [CMP_W-1:0] low_ext;
    logic                   changed;
    logic                   hit_high;
    logic                   hit_low;
    logic [EXT_W-1:0]       count_ext;

    // Direction of each edge from the other phase's previous level
    always_comb begin
        step_a = 3'sd0;
        step_b = 3'sd0;
        if (i_edges.new_a != i_edges.old_a) begin
            step_a = (i_edges.new_a == i_edges.old_b) ? 3'sd1 : -3'sd1;
        end
        if (i_edges.new_b != i_edges.old_b) begin
            step_b = (i_edges.new_b == i_edges.old_a) ? -3'sd1 : 3'sd1;
        end
    end

    assign delta   = step_a + step_b;
    assign changed = (delta != 3'sd0);
    assign sum     = r_count + COUNT_WIDTH'(delta);

    // Compare the new count against both limits, high first
    assign sum_ext  = CMP_W'($signed(sum));
    assign high_ext = $signed(CMP_W'(i_pos_limit));
    assign low_ext  = CMP_W'($signed(i_neg_limit));
    assign hit_high = changed && (sum_ext >= high_ext);
    assign hit_low  = changed && !hit_high && (sum_ext <= low_ext);

    // Clear on a limit, advance on an edge, else hold
    always_comb begin
        priority if (hit_high || hit_low) begin
            n_count = '0;
        end else if (changed) begin
            n_count = sum;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    assign count_ext                = EXT_W'(n_count);
    assign o_result.position_count  = count_ext[POS_W-1:0];
    assign o_result.limit_hit       = hit_high || hit_low;
    assign o_result.limit_which     = hit_low ? LIMIT_LOW : LIMIT_HIGH;

endmodule

`default_nettype wire

// File: sv/qec_checker.sv
// Port-level assertions for the quadrature encoder counter, with its bind.
`default_nettype none

module qec_checker
    import qec_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [POS_W-1:0]      o_position_count,
    input wire logic                  o_limit_hit,
    input wire logic                  o_limit_which
);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Every accepted sample shows a result word on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted sample gave no result word");

    // A limit event clears the count
    a_limit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_limit_hit) |-> (o_position_count == '0))
        else $error("count not cleared on limit event");

    // Limit select is low without a limit event
    a_which_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_limit_hit) |-> (o_limit_which == LIMIT_HIGH))
        else $error("limit select set without limit event");

endmodule

bind quadrature_encoder_counter qec_checker u_qec_checker (.*);

`default_nettype wire

// File: dv/quadrature_encoder_counter_test.sv
// Self-checking testbench for the quadrature encoder counter: predictor, stimulus, checks.
module quadrature_encoder_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qec_pkg::*;

    // Largest run the 10-bit filter counters can hold
    localparam int RUN_MAX = (1 << 10) - 1;
    // Index with no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Predicts one result word per sample and checks the block's words in order
    class qec_scoreboard;
        logic [HIGH_W-1:0]       pos_limit;
        logic signed [LOW_W-1:0] neg_limit;
        logic [GLITCH_W-1:0]     glitch_len;
        bit                      level_a;
        bit                      level_b;
        int                      run_a;
        int                      run_b;
        logic signed [POS_W-1:0] position;
        t_result                 expected_q[$];
        int                      n_words;
        int                      n_errors;
        int                      n_high_hits;
        int                      n_low_hits;

        function new();
            pos_limit   = POS_LIMIT_RST;
            neg_limit   = NEG_LIMIT_RST;
            glitch_len  = GLITCH_RST;
            level_a     = 1'b0;
            level_b     = 1'b0;
            run_a       = 0;
            run_b       = 0;
            position    = '0;
            n_words     = 0;
            n_errors    = 0;
            n_high_hits = 0;
            n_low_hits  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POS_LIMIT:      pos_limit  = data[HIGH_W-1:0];
                CFG_NEG_LIMIT:      neg_limit  = data[LOW_W-1:0];
                CFG_GLITCH_SAMPLES: glitch_len = data[GLITCH_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance one phase filter; return the accepted level after this sample
        function bit settle(bit raw, bit level, inout int run);
            int thresh;
            thresh = (int'(glitch_len) > RUN_MAX) ? RUN_MAX : int'(glitch_len);
            if (raw == level) begin
                run = 0;
                return level;
            end
            if (run >= thresh) begin
                run = 0;
                return raw;
            end
            if (run < RUN_MAX)
                run++;
            return level;
        endfunction

        // Take one accepted sample and queue the word it should produce
        function void note_sample(bit raw_a, bit raw_b);
            bit      new_a;
            bit      new_b;
            int      delta;
            int      pos;
            t_result res;
            new_a = settle(raw_a, level_a, run_a);
            new_b = settle(raw_b, level_b, run_b);
            delta = 0;
            if (new_a != level_a)
                delta += (new_a == level_b) ? 1 : -1;
            if (new_b != level_b)
                delta += (new_b == level_a) ? -1 : 1;
            level_a = new_a;
            level_b = new_b;
            res.limit_hit   = 1'b0;
            res.limit_which = LIMIT_HIGH;
            // Limits are only looked at when the count moved
            if (delta != 0) begin
                position = POS_W'(int'(position) + delta);
                pos = int'(position);
                if (pos >= int'(pos_limit)) begin
                    position        = '0;
                    res.limit_hit   = 1'b1;
                    res.limit_which = LIMIT_HIGH;
                    n_high_hits++;
                end else if (pos <= int'(neg_limit)) begin
                    position        = '0;
                    res.limit_hit   = 1'b1;
                    res.limit_which = LIMIT_LOW;
                    n_low_hits++;
                end
            end
            res.position_count = position;
            expected_q.push_back(res);
        endfunction

        // Compare one accepted word against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            n_words++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("tb: word with nothing expected: count %0d hit %0b which %0b",
                             $signed(got.position_count), got.limit_hit, got.limit_which);
                return;
            end
            want = expected_q.pop_front();
            if (got.position_count !== want.position_count ||
                    got.limit_hit !== want.limit_hit ||
                    got.limit_which !== want.limit_which) begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"tb: word %0d mismatch: expected count %0d hit %0b which %0b,",
                              " got count %0d hit %0b which %0b"},
                             n_words, $signed(want.position_count), want.limit_hit,
                             want.limit_which, $signed(got.position_count), got.limit_hit,
                             got.limit_which);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_phase_a   = 1'b0;
    logic                  i_phase_b   = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [POS_W-1:0]      o_position_count;
    logic                  o_limit_hit;
    logic                  o_limit_which;

    qec_scoreboard sb = new();

    bit pace_on         = 1'b1;
    int hold_off_cycles = 0;
    int n_sent          = 0;
    int n_writes        = 0;
    int glitch_now      = int'(GLITCH_RST);
    int gray_idx        = 0;
    int walk_dir        = 1;

    quadrature_encoder_counter u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check finished words first, then take the sample accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_position_count, o_limit_hit, o_limit_which});
            if (i_in_valid && !o_in_stall)
                sb.note_sample(i_phase_a, i_phase_b);
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (pace_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit [1:0] gray_of(int idx);
        bit [1:0] i2;
        i2 = idx[1:0];
        return i2 ^ (i2 >> 1);
    endfunction

    // Offer one sample word and hold it until the block takes it
    task automatic send_sample(bit a, bit b);
        if (pace_on && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_phase_a  <= a;
        i_phase_b  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_level(bit a, bit b, int n);
        repeat (n) send_sample(a, b);
    endtask

    // Move the encoder one quadrature step and hold it long enough to pass the filter
    task automatic step_encoder(int dir);
        bit [1:0] nxt;
        gray_idx = (gray_idx + dir) & 3;
        nxt = gray_of(gray_idx);
        hold_level(nxt[1], nxt[0], glitch_now + 1 + $urandom_range(0, 2));
    endtask

    // Flip both phases at once; their opposite steps cancel
    task automatic jump_both();
        step_encoder(2);
    endtask

    // Short pulse on one phase that the filter must swallow
    task automatic glitch_pulse();
        bit [1:0] lvl;
        int       len;
        if (glitch_now == 0)
            return;
        lvl = gray_of(gray_idx);
        len = $urandom_range(1, (glitch_now < 12) ? glitch_now : 12);
        if ($urandom_range(0, 1))
            hold_level(!lvl[1], lvl[0], len);
        else
            hold_level(lvl[1], !lvl[0], len);
        hold_level(lvl[1], lvl[0], 1);
    endtask

    // Random levels, then settle back on the current encoder position
    task automatic noise_burst(int n);
        bit [1:0] lvl;
        repeat (n) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        lvl = gray_of(gray_idx);
        hold_level(lvl[1], lvl[0], glitch_now + 1);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        if (idx == CFG_GLITCH_SAMPLES)
            glitch_now = int'(data[GLITCH_W-1:0]);
        n_writes++;
        @(negedge i_clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] high, logic [CFG_DATA_W-1:0] low,
                             logic [CFG_DATA_W-1:0] glitch);
        write_reg(CFG_POS_LIMIT, high);
        write_reg(CFG_NEG_LIMIT, low);
        write_reg(CFG_GLITCH_SAMPLES, glitch);
    endtask

    // Drop valid and wait for every predicted word, plus the pipeline latency
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly clean encoder motion, with reversals, glitches and noise mixed in
    task automatic walk_phase(int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1: noise_burst($urandom_range(1, 6));
                2, 3: glitch_pulse();
                4:    jump_both();
                5, 6: begin
                    walk_dir = -walk_dir;
                    step_encoder(walk_dir);
                end
                default: step_encoder(walk_dir);
            endcase
        end
    endtask

    initial begin
        int random_from;
        int phase_no;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: pulses shorter than the default filter change nothing
        hold_level(1'b1, 1'b0, 5);
        hold_level(1'b0, 1'b1, 7);
        hold_level(1'b0, 1'b0, 2);
        drain();

        // No filtering, tight limits: hit high, hit low, both phases at once, noise
        configure(16'd2, CFG_DATA_W'(-2), 16'd0);
        step_encoder(1);
        step_encoder(1);
        step_encoder(-1);
        step_encoder(-1);
        jump_both();
        noise_burst(4);
        drain();

        // Long filter, smallest limits: one edge after a long hold
        configure(16'd1, CFG_DATA_W'(-1), 16'd200);
        glitch_pulse();
        step_encoder(1);
        drain();

        // Limits out of range: high limit masks to zero, low limit above zero
        configure(16'h8000, 16'd5, 16'd1);
        walk_phase(60);
        drain();

        // Widest limits, plus a write to the unused index
        configure(16'h7FFF, 16'h8000, 16'd2);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        walk_phase(60);
        drain();

        // Random settings; the second phase holds off the receiver for a long stretch
        random_from = n_sent;
        phase_no = 0;
        while (n_sent < random_from + 280) begin
            write_reg(CFG_POS_LIMIT, ($urandom_range(0, 5) == 0) ?
                      CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(1, 16)));
            write_reg(CFG_NEG_LIMIT, ($urandom_range(0, 5) == 0) ?
                      CFG_DATA_W'($urandom) : CFG_DATA_W'(-int'($urandom_range(1, 16))));
            write_reg(CFG_GLITCH_SAMPLES, ($urandom_range(0, 7) == 0) ?
                      CFG_DATA_W'($urandom_range(7, 30)) : CFG_DATA_W'($urandom_range(0, 6)));
            if (phase_no == 1) begin
                walk_phase(10);
                hold_off_cycles = 150;
            end
            walk_phase($urandom_range(40, 90));
            drain();
            phase_no++;
        end

        // Closing stretch at full rate
        pace_on = 1'b0;
        configure(CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'(-int'($urandom_range(1, 12))),
                  CFG_DATA_W'($urandom_range(0, 3)));
        walk_phase(100);
        drain();

        $display("tb: %0d samples sent, %0d result words checked, %0d register writes",
                 n_sent, sb.n_words, n_writes);
        $display("tb: limit events predicted: %0d high, %0d low", sb.n_high_hits,
                 sb.n_low_hits);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatching words", sb.n_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
